// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector cache clock policy: shared package
// Word formats, operation codes and engine states for the tag/policy engine.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncFlush = 2'd2;
  localparam logic [1:0] FuncNop   = 2'd3;

  // Most writebacks that one flush word may report.
  localparam int MaxResults = 64;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] sector;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        fetch;
    logic        writeback;
    logic [31:0] writeback_sector;
    logic        last;
  } out_word_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] sector;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_SWEEP,
    ST_VRD,
    ST_VCAP,
    ST_EMIT,
    ST_FSCAN,
    ST_FRD,
    ST_FCAP,
    ST_FEND
  } eng_state_t;

endpackage

// ===== hw/rtl/sector_cache_clock_policy_core.sv =====
// ----------------------------------------------------------------------------
// Sector cache clock policy core
// Tag and clock-replacement engine for a fully associative write-back cache.
// ----------------------------------------------------------------------------
// A read or write word searches the tag store one entry at a time, each entry
// read (ST_SRD) and then compared (ST_SCMP) through the one tag memory read port;
// a miss then sweeps the clock hand past referenced entries, reads the victim's
// tag (ST_VRD, ST_VCAP) and writes the new one. A flush walks every entry once,
// reading the tag of each dirty one. A two-word queue in front lets requests be
// taken while the engine works, and a result register lets the engine finish
// while a result word waits at the output.
module sector_cache_clock_policy_core #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output scc_pkg::out_word_t out_word
);

  logic          cmd_valid;
  logic          cmd_pop;
  scc_pkg::cmd_t cmd;

  scc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  scc_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.hit |-> !out_word.fetch && !out_word.writeback)
    else $error("hit word asks for a fetch or writeback");

  a_wb_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.writeback |-> out_word.writeback_sector == 32'd0)
    else $error("writeback sector set without writeback");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word presented straight after reset");
`endif

endmodule

// ===== hw/rtl/scc_front.sv =====
// ----------------------------------------------------------------------------
// Sector cache front end
// Accepts request words, decodes the operation and queues them for the engine.
// ----------------------------------------------------------------------------
module scc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  scc_pkg::in_word_t in_word,
  output logic              cmd_valid,
  output scc_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  scc_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          push, pop;
  scc_pkg::cmd_t dec;

  assign in_stall  = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // The unused function code is swallowed here and never reaches the engine.
  assign push = in_valid && !in_stall && (in_word.func != scc_pkg::FuncNop);
  assign pop  = cmd_pop && cmd_valid;

  always_comb begin
    dec.sector = in_word.sector;
    priority if (in_word.func == scc_pkg::FuncWrite) begin
      dec.op = scc_pkg::OP_WRITE;
    end else if (in_word.func == scc_pkg::FuncFlush) begin
      dec.op = scc_pkg::OP_FLUSH;
    end else begin
      dec.op = scc_pkg::OP_READ;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== hw/rtl/scc_engine.sv =====
// ----------------------------------------------------------------------------
// Sector cache back end
// Tag search, clock sweep, flush walk and the result register.
// ----------------------------------------------------------------------------
module scc_engine #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  scc_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output scc_pkg::out_word_t out_word
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);
  localparam logic [6:0] MaxCnt = 7'(scc_pkg::MaxResults);

  scc_pkg::eng_state_t state_r, state_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  dirty_r, dirty_nxt;
  logic [ENTRIES-1:0]  ref_r, ref_nxt;
  logic [IW-1:0]       hand_r, hand_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  scc_pkg::op_t        op_r, op_nxt;
  logic [31:0]         sector_r, sector_nxt;
  logic                pend_v_r, pend_v_nxt;
  scc_pkg::out_word_t  pend_r, pend_nxt;
  scc_pkg::out_word_t  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  scc_pkg::out_word_t  out_word_r, out_word_nxt;

  logic [31:0]   tag_mem [ENTRIES];
  logic [31:0]   rdata_r;
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_addr;
  logic          out_free;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_addr] <= sector_r;
    end
    if (mem_re) begin
      rdata_r <= tag_mem[mem_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    ref_nxt       = ref_r;
    hand_nxt      = hand_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    sector_nxt    = sector_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    cmd_pop       = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = idx_r;

    unique case (state_r)
      scc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          op_nxt     = cmd.op;
          sector_nxt = cmd.sector;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (cmd.op == scc_pkg::OP_FLUSH) ? scc_pkg::ST_FSCAN
                                                      : scc_pkg::ST_SRD;
        end
      end
      scc_pkg::ST_SRD: begin
        mem_re    = 1'b1;
        state_nxt = scc_pkg::ST_SCMP;
      end
      scc_pkg::ST_SCMP: begin
        if (valid_r[idx_r] && rdata_r == sector_r) begin
          ref_nxt[idx_r] = 1'b1;
          if (op_r == scc_pkg::OP_WRITE) begin
            dirty_nxt[idx_r] = 1'b1;
          end
          res_nxt   = '{slot: 6'(idx_r), hit: 1'b1, fetch: 1'b0, writeback: 1'b0,
                        writeback_sector: 32'd0, last: 1'b1};
          state_nxt = scc_pkg::ST_EMIT;
        end else if (idx_r == LastIdx) begin
          state_nxt = scc_pkg::ST_SWEEP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = scc_pkg::ST_SRD;
        end
      end
      scc_pkg::ST_SWEEP: begin
        // A free or unreferenced entry stops the hand; a referenced one
        // loses its bit and is passed over.
        if (!valid_r[hand_r] || !ref_r[hand_r]) begin
          mem_addr  = hand_r;
          mem_re    = 1'b1;
          state_nxt = scc_pkg::ST_VRD;
        end else begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt = (hand_r == LastIdx) ? '0 : hand_r + 1'b1;
        end
      end
      scc_pkg::ST_VRD: begin
        state_nxt = scc_pkg::ST_VCAP;
      end
      scc_pkg::ST_VCAP: begin
        mem_addr         = hand_r;
        mem_we           = 1'b1;
        res_nxt          = '{slot: 6'(hand_r), hit: 1'b0, fetch: 1'b1,
                             writeback: 1'b0, writeback_sector: 32'd0, last: 1'b1};
        if (valid_r[hand_r] && dirty_r[hand_r]) begin
          res_nxt.writeback        = 1'b1;
          res_nxt.writeback_sector = rdata_r;
        end
        valid_nxt[hand_r] = 1'b1;
        ref_nxt[hand_r]   = 1'b1;
        dirty_nxt[hand_r] = (op_r == scc_pkg::OP_WRITE);
        state_nxt         = scc_pkg::ST_EMIT;
      end
      scc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = scc_pkg::ST_IDLE;
        end
      end
      scc_pkg::ST_FSCAN: begin
        if (valid_r[idx_r] && dirty_r[idx_r]) begin
          mem_re    = 1'b1;
          state_nxt = scc_pkg::ST_FRD;
        end else if (idx_r == LastIdx) begin
          state_nxt = scc_pkg::ST_FEND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      scc_pkg::ST_FRD: begin
        state_nxt = scc_pkg::ST_FCAP;
      end
      scc_pkg::ST_FCAP: begin
        // The previous writeback is held back until the next one is found,
        // so that the final word of the flush can be marked.
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = pend_r;
          end
          pend_v_nxt       = 1'b1;
          pend_nxt         = '{slot: 6'(idx_r), hit: 1'b0, fetch: 1'b0,
                               writeback: 1'b1, writeback_sector: rdata_r,
                               last: 1'b0};
          dirty_nxt[idx_r] = 1'b0;
          cnt_nxt          = cnt_r + 7'd1;
          if (cnt_r + 7'd1 == MaxCnt || idx_r == LastIdx) begin
            state_nxt = scc_pkg::ST_FEND;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = scc_pkg::ST_FSCAN;
          end
        end
      end
      scc_pkg::ST_FEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_word_nxt      = pend_r;
            out_word_nxt.last = 1'b1;
          end else begin
            out_word_nxt = '{slot: 6'd0, hit: 1'b0, fetch: 1'b0, writeback: 1'b0,
                             writeback_sector: 32'd0, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scc_pkg::ST_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      ref_r       <= '0;
      hand_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      ref_r       <= ref_nxt;
      hand_r      <= hand_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    sector_r   <= sector_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== bench/sector_cache_clock_policy_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sector cache clock policy core: testbench
// Drives read, write and flush words with random gaps and stalls, predicts
// every result word from a private copy of the tag and policy state, and
// compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module sector_cache_clock_policy_core_tb;

  localparam int Slots = 64;
  localparam int IdleLimit = 20000;

  class slot_book;
    bit                 occ[Slots];
    logic [31:0]        tag[Slots];
    bit                 dirt[Slots];
    bit                 refd[Slots];
    logic [5:0]         hand;
    scc_pkg::out_word_t pending[$];
    int                 errors;

    function void clear();
      for (int i = 0; i < Slots; i++) begin
        occ[i] = 0; tag[i] = '0; dirt[i] = 0; refd[i] = 0;
      end
      hand = '0;
      pending.delete();
      errors = 0;
    endfunction

    function void note_word(scc_pkg::in_word_t w);
      scc_pkg::out_word_t r;
      int slot;
      bit found;
      if (w.func == scc_pkg::FuncNop) return;
      if (w.func == scc_pkg::FuncFlush) begin
        int k;
        k = 0;
        for (int i = 0; i < Slots && k < scc_pkg::MaxResults; i++) begin
          if (occ[i] && dirt[i]) begin
            r = '0;
            r.slot = i[5:0]; r.writeback = 1'b1; r.writeback_sector = tag[i];
            pending.push_back(r);
            dirt[i] = 0;
            k++;
          end
        end
        if (k == 0) begin
          r = '0; r.last = 1'b1; pending.push_back(r);
        end else begin
          pending[pending.size()-1].last = 1'b1;
        end
        return;
      end
      r = '0;
      found = 0;
      slot = 0;
      for (int i = 0; i < Slots; i++) begin
        if (!found && occ[i] && tag[i] == w.sector) begin
          found = 1; slot = i;
        end
      end
      if (!found) begin
        // The hand sweeps, clearing reference bits, until a free or
        // unreferenced entry turns up.
        for (int n = 0; n <= Slots; n++) begin
          if (!occ[hand] || !refd[hand]) break;
          refd[hand] = 0;
          hand = hand + 1'b1;
        end
        slot = int'(hand);
        if (occ[slot] && dirt[slot]) begin
          r.writeback = 1'b1; r.writeback_sector = tag[slot];
        end
        occ[slot] = 1; tag[slot] = w.sector; dirt[slot] = 0;
      end
      refd[slot] = 1;
      if (w.func == scc_pkg::FuncWrite) dirt[slot] = 1;
      r.slot = slot[5:0]; r.hit = found; r.fetch = !found; r.last = 1'b1;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("result word mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_word(scc_pkg::out_word_t g);
      scc_pkg::out_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 32'(g.slot), 32'd0);
        return;
      end
      e = pending.pop_front();
      if (g.slot != e.slot) report("slot", 32'(g.slot), 32'(e.slot));
      if (g.hit != e.hit) report("hit", 32'(g.hit), 32'(e.hit));
      if (g.fetch != e.fetch) report("fetch", 32'(g.fetch), 32'(e.fetch));
      if (g.writeback != e.writeback)
        report("writeback", 32'(g.writeback), 32'(e.writeback));
      if (g.writeback_sector != e.writeback_sector)
        report("writeback_sector", g.writeback_sector, e.writeback_sector);
      if (g.last != e.last) report("last", 32'(g.last), 32'(e.last));
    endtask
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  scc_pkg::in_word_t in_word;
  scc_pkg::out_word_t out_word;
  slot_book book;
  int idle_cycles, words_sent, results_seen;

  sector_cache_clock_policy_core uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Sampling happens at the edge, before the nonblocking updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) book.note_word(in_word);
      if (out_valid && !out_stall) begin
        book.check_word(out_word);
        results_seen++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d results pending", book.pending.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int stall_len;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      stall_len = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      repeat (stall_len) begin
        @(posedge clk);
        out_stall <= 1'b1;
      end
      @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task send_word(logic [1:0] f, logic [31:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(posedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
    @(posedge clk);
    in_valid <= 1'b1;
    in_word <= '{func: f, sector: s};
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    in_word <= '{func: 2'($urandom_range(0, 3)), sector: 32'($urandom)};
    words_sent++;
  endtask

  task wait_drained();
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // Sectors from a small pool so that hits, evictions and flushes recur.
  function automatic logic [31:0] pool_sector(int spread);
    return 32'(32'h1000 + $urandom_range(0, spread));
  endfunction

  initial begin
    int f;
    book = new();
    book.clear();
    idle_cycles = 0; words_sent = 0; results_seen = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty flush, extreme sectors, hits, writes, the ignored code.
    send_word(scc_pkg::FuncFlush, 32'h0);
    send_word(scc_pkg::FuncRead, 32'h0);
    send_word(scc_pkg::FuncRead, 32'hFFFF_FFFF);
    send_word(scc_pkg::FuncRead, 32'h0);
    send_word(scc_pkg::FuncWrite, 32'hFFFF_FFFF);
    send_word(scc_pkg::FuncWrite, 32'h5555_5555);
    send_word(scc_pkg::FuncNop, 32'hAAAA_AAAA);
    send_word(scc_pkg::FuncWrite, 32'hAAAA_AAAA);
    send_word(scc_pkg::FuncFlush, 32'hFFFF_FFFF);
    send_word(scc_pkg::FuncFlush, 32'h1234_5678);
    wait_drained();

    // Fill every slot with writes, then miss with all referenced: full sweep,
    // dirty victim, and a flush reporting many entries.
    for (int i = 0; i < Slots; i++) send_word(scc_pkg::FuncWrite, 32'(32'h8000_0000 + i));
    send_word(scc_pkg::FuncRead, 32'h7FFF_FFFF);
    send_word(scc_pkg::FuncRead, 32'h8000_0005);
    send_word(scc_pkg::FuncFlush, 32'h0);

    for (int n = 0; n < 24; n++) begin
      f = $urandom_range(0, 19);
      if (f < 8) begin
        send_word(scc_pkg::FuncRead, pool_sector(($urandom_range(0, 1)) ? 40 : 120));
      end else if (f < 15) begin
        send_word(scc_pkg::FuncWrite, pool_sector(100));
      end else if (f < 17) begin
        send_word(scc_pkg::FuncFlush, 32'($urandom));
      end else if (f < 18) begin
        send_word(scc_pkg::FuncNop, 32'($urandom));
      end else begin
        send_word(2'($urandom_range(0, 1)), 32'($urandom));
      end
      if (n == 12) wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    $display("Sent %0d words and checked %0d result words covering hits, misses,",
             words_sent, results_seen);
    $display("clock sweeps, dirty evictions and flushes.");
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
